// File: rtl/diff_drive_pose_integrator_macros.svh
`ifndef DIFF_DRIVE_POSE_INTEGRATOR_MACROS_SVH
`define DIFF_DRIVE_POSE_INTEGRATOR_MACROS_SVH

// same-cycle implication, checked on clk with reset masked
`define DDPI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define DDPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ddpi_pkg.sv
package ddpi_pkg;

  // field widths
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 16;
  localparam int SPD_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SUM_W      = POS_W + 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_DIAMETER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_X          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING    = 3'd5;

  // angles, Q3.13
  localparam logic signed [HEAD_W-1:0] PI_Q13          = 16'sd25736;
  localparam logic signed [HEAD_W-1:0] PI_MAX_Q13      = 16'sd25735;
  localparam logic signed [HEAD_W-1:0] NEG_PI_Q13      = -16'sd25736;
  localparam logic signed [HEAD_W-1:0] HALF_PI_Q13     = 16'sd12868;
  localparam logic signed [HEAD_W-1:0] NEG_HALF_PI_Q13 = -16'sd12868;

  // angle wrap: bias by pi plus 2^10 turns, then restoring reduction
  localparam int ANG_W            = 28;
  localparam int WRAP_TURNS_LOG2  = 10;
  localparam int WRAP_STEPS       = WRAP_TURNS_LOG2 + 1;
  localparam int WRAP_CNT_W       = $clog2(WRAP_STEPS);
  localparam int TWO_PI_INT       = 51472;
  localparam int PI_INT           = 25736;
  localparam logic [ANG_W-1:0] WRAP_DIV0 = ANG_W'(TWO_PI_INT * (2 ** WRAP_TURNS_LOG2));
  localparam logic [ANG_W-1:0] WRAP_BIAS =
    ANG_W'(PI_INT + TWO_PI_INT * (2 ** WRAP_TURNS_LOG2));

  // cordic, Q2.30
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CNT_W        = $clog2(ATAN_ENTRIES);
  localparam int CORD_W       = 33;
  localparam int Z_SHIFT      = 17;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;

  // serial multiplier
  localparam int MUL_A_W     = 34;
  localparam int MUL_B_W     = 34;
  localparam int SHORT_STEPS = 17;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int ACC_W       = MUL_A_W + 1 + MUL_B_W;
  localparam int MUL_CNT_W   = $clog2(MUL_B_W);
  localparam int SHORT_EXT   = PROD_W - (ACC_W - MUL_B_W + SHORT_STEPS);

  localparam int POS_SHIFT = 38;
  localparam int DX_W      = PROD_W - POS_SHIFT;

  typedef struct packed {
    logic start;
    logic long_mode;
  } mul_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_LOAD,
    ST_M1,
    ST_M2,
    ST_P,
    ST_WMID,
    ST_COR,
    ST_DDT,
    ST_MC,
    ST_MS,
    ST_WHD,
    ST_DONE
  } state_t;

  function automatic logic signed [CORD_W-1:0] atan_q30(input logic [CNT_W-1:0] idx);
    logic signed [CORD_W-1:0] v;
    case (idx)
      5'd0:    v = 33'sd843314856;
      5'd1:    v = 33'sd497837829;
      5'd2:    v = 33'sd263043836;
      5'd3:    v = 33'sd133525158;
      5'd4:    v = 33'sd67021686;
      5'd5:    v = 33'sd33543515;
      5'd6:    v = 33'sd16775850;
      5'd7:    v = 33'sd8388437;
      5'd8:    v = 33'sd4194282;
      5'd9:    v = 33'sd2097149;
      5'd10:   v = 33'sd1048575;
      5'd11:   v = 33'sd524287;
      5'd12:   v = 33'sd262143;
      5'd13:   v = 33'sd131071;
      5'd14:   v = 33'sd65535;
      5'd15:   v = 33'sd32767;
      5'd16:   v = 33'sd16383;
      5'd17:   v = 33'sd8191;
      5'd18:   v = 33'sd4095;
      5'd19:   v = 33'sd2047;
      5'd20:   v = 33'sd1023;
      5'd21:   v = 33'sd511;
      5'd22:   v = 33'sd255;
      5'd23:   v = 33'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > SUM_W'(signed'({1'b0, {(POS_W-1){1'b1}}}))) begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end else if (v < SUM_W'(signed'({1'b1, {(POS_W-1){1'b0}}}))) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/diff_drive_pose_integrator.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   in_kind, in_lin_speed, in_turn_rate
// out      output     out_valid / out_stall out_pos_x, out_pos_y, out_heading
// cfg      input      cfg_wr_en             cfg_index, cfg_data
//
// a load item wraps the start heading only; a move item takes six products,
// two wraps and a cordic run; its time is set by the bit-serial multiplier,
// one bit per cycle (17 bits for a 16 bit factor, 34 for a cordic output)
// one item is worked at a time; the next one is taken while the result waits
// rst_n is synchronous: pose to zero, registers to their defaults
// out_stall holds the result register; the pose is updated anyway

`include "diff_drive_pose_integrator_macros.svh"

module diff_drive_pose_integrator import ddpi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_kind,
  input  logic signed [SPD_W-1:0] in_lin_speed,
  input  logic signed [SPD_W-1:0] in_turn_rate,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [HEAD_W-1:0] out_heading,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]         wheel_radius_r;
  logic [CFG_W-1:0]         inverse_diameter_r;
  logic [CFG_W-1:0]         time_step_r;
  logic signed [POS_W-1:0]  start_x_r;
  logic signed [POS_W-1:0]  start_y_r;
  logic signed [HEAD_W-1:0] start_heading_r;

  logic                     kind_r;
  logic signed [SPD_W-1:0]  lin_r;
  logic signed [SPD_W-1:0]  turn_r;

  logic signed [POS_W-1:0]  cur_x_r, cur_x_nxt;
  logic signed [POS_W-1:0]  cur_y_r, cur_y_nxt;
  logic signed [HEAD_W-1:0] cur_h_r, cur_h_nxt;
  logic signed [ANG_W-1:0]  full_r, full_nxt;
  logic signed [MUL_A_W-1:0] ddt_r, ddt_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0]  out_x_r, out_x_nxt;
  logic signed [POS_W-1:0]  out_y_r, out_y_nxt;
  logic signed [HEAD_W-1:0] out_h_r, out_h_nxt;

  mul_ctrl_t                mul_ctl;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                     mul_done;
  logic signed [PROD_W-1:0] mul_prod;

  logic                     wrap_start;
  logic signed [ANG_W-1:0]  wrap_a;
  logic                     wrap_done;
  logic signed [HEAD_W-1:0] wrap_res;

  logic                     cor_start;
  logic                     cor_done;
  logic signed [CORD_W-1:0] cor_cos;
  logic signed [CORD_W-1:0] cor_sin;

  logic [50:0]              dth_sum, half_sum, full_sum;
  logic signed [MUL_A_W-1:0] dth;
  logic signed [ANG_W-2:0]  half_turn;
  logic signed [ANG_W-1:0]  full_turn;
  logic [PROD_W-1:0]        dx_sum;
  logic signed [DX_W-1:0]   dx;
  logic signed [POS_W-1:0]  pos_base;
  logic signed [SUM_W-1:0]  pos_sum;

  ddpi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ddpi_wrap u_wrap (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (wrap_start),
    .a_in   (wrap_a),
    .done   (wrap_done),
    .result (wrap_res)
  );

  ddpi_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (wrap_res),
    .done    (cor_done),
    .cos_out (cor_cos),
    .sin_out (cor_sin)
  );

  // turn rate: (2*w*R*D + 2^15) >> 16
  assign dth_sum   = mul_prod[50:0] + 51'd16384;
  assign dth       = dth_sum[48:15];
  // half and full heading step from p = dth * T
  assign half_sum  = mul_prod[50:0] + 51'd8388608;
  assign full_sum  = mul_prod[50:0] + 51'd4194304;
  assign half_turn = half_sum[50:24];
  assign full_turn = full_sum[50:23];

  assign dx_sum   = mul_prod + (PROD_W'(1) << (POS_SHIFT-1));
  assign dx       = dx_sum[PROD_W-1:POS_SHIFT];
  assign pos_base = (state_r == ST_MC) ? cur_x_r : cur_y_r;
  assign pos_sum  = SUM_W'(pos_base) + SUM_W'(dx);

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    cur_h_nxt     = cur_h_r;
    full_nxt      = full_r;
    ddt_nxt       = ddt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_h_nxt     = out_h_r;
    mul_ctl       = '0;
    mul_a         = '0;
    mul_b         = '0;
    wrap_start    = 1'b0;
    wrap_a        = '0;
    cor_start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_BEGIN;
        end
      end
      ST_BEGIN: begin
        if (kind_r) begin
          wrap_start = 1'b1;
          wrap_a     = ANG_W'(start_heading_r);
          state_nxt  = ST_LOAD;
        end else begin
          mul_ctl.start = 1'b1;
          mul_a         = MUL_A_W'(turn_r);
          mul_b         = MUL_B_W'(wheel_radius_r);
          state_nxt     = ST_M1;
        end
      end
      ST_LOAD: begin
        if (wrap_done) begin
          cur_x_nxt = start_x_r;
          cur_y_nxt = start_y_r;
          cur_h_nxt = wrap_res;
          state_nxt = ST_DONE;
        end
      end
      ST_M1: begin
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          mul_a         = mul_prod[MUL_A_W-1:0];
          mul_b         = MUL_B_W'(inverse_diameter_r);
          state_nxt     = ST_M2;
        end
      end
      ST_M2: begin
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          mul_a         = dth;
          mul_b         = MUL_B_W'(time_step_r);
          state_nxt     = ST_P;
        end
      end
      ST_P: begin
        if (mul_done) begin
          full_nxt   = full_turn;
          wrap_start = 1'b1;
          wrap_a     = ANG_W'(cur_h_r) + ANG_W'(half_turn);
          state_nxt  = ST_WMID;
        end
      end
      ST_WMID: begin
        if (wrap_done) begin
          cor_start = 1'b1;
          state_nxt = ST_COR;
        end
      end
      ST_COR: begin
        if (cor_done) begin
          mul_ctl.start = 1'b1;
          mul_a         = MUL_A_W'(lin_r);
          mul_b         = MUL_B_W'(time_step_r);
          state_nxt     = ST_DDT;
        end
      end
      ST_DDT: begin
        if (mul_done) begin
          ddt_nxt           = mul_prod[MUL_A_W-1:0];
          mul_ctl.start     = 1'b1;
          mul_ctl.long_mode = 1'b1;
          mul_a             = mul_prod[MUL_A_W-1:0];
          mul_b             = MUL_B_W'(cor_cos);
          state_nxt         = ST_MC;
        end
      end
      ST_MC: begin
        if (mul_done) begin
          cur_x_nxt         = sat32(pos_sum);
          mul_ctl.start     = 1'b1;
          mul_ctl.long_mode = 1'b1;
          mul_a             = ddt_r;
          mul_b             = MUL_B_W'(cor_sin);
          state_nxt         = ST_MS;
        end
      end
      ST_MS: begin
        if (mul_done) begin
          cur_y_nxt  = sat32(pos_sum);
          wrap_start = 1'b1;
          wrap_a     = ANG_W'(cur_h_r) + full_r;
          state_nxt  = ST_WHD;
        end
      end
      ST_WHD: begin
        if (wrap_done) begin
          cur_h_nxt = wrap_res;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = cur_x_r;
          out_y_nxt     = cur_y_r;
          out_h_nxt     = cur_h_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cur_h_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      cur_h_r     <= cur_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    full_r  <= full_nxt;
    ddt_r   <= ddt_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_h_r <= out_h_nxt;
    if (in_valid && !in_stall) begin
      kind_r <= in_kind;
      lin_r  <= in_lin_speed;
      turn_r <= in_turn_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_radius_r     <= 16'd5243;
      inverse_diameter_r <= 16'd1600;
      time_step_r        <= 16'd655;
      start_x_r          <= '0;
      start_y_r          <= '0;
      start_heading_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WHEEL_RADIUS:     wheel_radius_r     <= cfg_data[CFG_W-1:0];
        REG_INVERSE_DIAMETER: inverse_diameter_r <= cfg_data[CFG_W-1:0];
        REG_TIME_STEP:        time_step_r        <= cfg_data[CFG_W-1:0];
        REG_START_X:          start_x_r          <= cfg_data[POS_W-1:0];
        REG_START_Y:          start_y_r          <= cfg_data[POS_W-1:0];
        REG_START_HEADING:    start_heading_r    <= cfg_data[HEAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_x_r;
  assign out_pos_y   = out_y_r;
  assign out_heading = out_h_r;

  `DDPI_ASSERT_NOW(a_one_unit_start, 1'b1, $onehot0({mul_ctl.start, wrap_start, cor_start}), "two units started in one cycle")
  `DDPI_ASSERT_NOW(a_mul_owner, mul_done, state_r == ST_M1 || state_r == ST_M2 || state_r == ST_P || state_r == ST_DDT || state_r == ST_MC || state_r == ST_MS, "product finished outside a multiply step")
  `DDPI_ASSERT_NOW(a_wrap_owner, wrap_done, state_r == ST_LOAD || state_r == ST_WMID || state_r == ST_WHD, "wrap finished outside an angle step")
  `DDPI_ASSERT_NOW(a_heading_range, state_r == ST_DONE, (cur_h_r >= NEG_PI_Q13) && (cur_h_r <= PI_MAX_Q13), "heading left the wrapped range")
  `DDPI_ASSERT_NEXT(a_result_out, (state_r == ST_DONE) && (!out_valid_r || !out_stall), out_valid_r && (state_r == ST_IDLE), "finished pose not handed to the output register")

endmodule

// File: rtl/ddpi_mul.sv
module ddpi_mul import ddpi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mul_ctrl_t                 ctl,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic                      done,
  output logic signed [PROD_W-1:0]  prod
);

  logic signed [MUL_A_W-1:0] a_r, a_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [MUL_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic                      long_r, long_nxt;

  logic signed [MUL_A_W:0]   hi;
  logic signed [MUL_A_W:0]   a_ext;
  logic signed [MUL_A_W:0]   addend;
  logic signed [MUL_A_W:0]   sum;
  logic [MUL_CNT_W-1:0]      cnt_last;
  logic                      last;
  logic [MUL_B_W-1:0]        b_load;

  assign hi       = acc_r[ACC_W-1:MUL_B_W];
  assign a_ext    = (MUL_A_W+1)'(a_r);
  assign cnt_last = long_r ? MUL_CNT_W'(MUL_B_W-1) : MUL_CNT_W'(SHORT_STEPS-1);
  assign last     = (cnt_r == cnt_last);
  // the multiplier's top bit carries negative weight
  assign addend   = acc_r[0] ? (last ? -a_ext : a_ext) : '0;
  assign sum      = hi + addend;
  assign b_load   = ctl.long_mode ? b
                  : {{(MUL_B_W-SHORT_STEPS){1'b0}}, b[SHORT_STEPS-1:0]};

  always_comb begin
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    long_nxt = long_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      a_nxt    = a;
      acc_nxt  = {{(MUL_A_W+1){1'b0}}, b_load};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      long_nxt = ctl.long_mode;
    end else if (busy_r) begin
      acc_nxt = {sum[MUL_A_W], sum, acc_r[MUL_B_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      long_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      long_r <= long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
  end

  // short products sit higher since fewer shifts were made
  assign prod = long_r ? signed'(acc_r[PROD_W-1:0])
              : signed'({{SHORT_EXT{acc_r[ACC_W-1]}},
                         acc_r[ACC_W-1:MUL_B_W-SHORT_STEPS]});
  assign done = done_r;

endmodule

// File: rtl/ddpi_wrap.sv
module ddpi_wrap import ddpi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [ANG_W-1:0]  a_in,
  output logic                     done,
  output logic signed [HEAD_W-1:0] result
);

  logic [ANG_W-1:0]      val_r, val_nxt;
  logic [ANG_W-1:0]      div_r, div_nxt;
  logic [WRAP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  always_comb begin
    val_nxt  = val_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // bias makes the value positive and below 2^11 turns
      val_nxt  = a_in + WRAP_BIAS;
      div_nxt  = WRAP_DIV0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (val_r >= div_r) begin
        val_nxt = val_r - div_r;
      end
      div_nxt = div_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == WRAP_CNT_W'(WRAP_STEPS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    div_r <= div_nxt;
  end

  assign result = signed'(val_r[HEAD_W-1:0] - PI_Q13);
  assign done   = done_r;

endmodule

// File: rtl/ddpi_cordic.sv
module ddpi_cordic import ddpi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [HEAD_W-1:0] angle,
  output logic                     done,
  output logic signed [CORD_W-1:0] cos_out,
  output logic signed [CORD_W-1:0] sin_out
);

  logic signed [CORD_W-1:0] x_r, x_nxt;
  logic signed [CORD_W-1:0] y_r, y_nxt;
  logic signed [CORD_W-1:0] z_r, z_nxt;
  logic                     neg_r, neg_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;

  logic signed [HEAD_W-1:0] ang_fold;
  logic                     neg_fold;
  logic signed [CORD_W-1:0] xs, ys, at;

  // fold into the right half plane, flipping both outputs
  always_comb begin
    ang_fold = angle;
    neg_fold = 1'b0;
    if (angle > HALF_PI_Q13) begin
      ang_fold = angle - PI_Q13;
      neg_fold = 1'b1;
    end else if (angle < NEG_HALF_PI_Q13) begin
      ang_fold = angle + PI_Q13;
      neg_fold = 1'b1;
    end
  end

  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = atan_q30(cnt_r);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = CORD_W'(ang_fold) <<< Z_SHIFT;
      neg_nxt  = neg_fold;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[CORD_W-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CORDIC_STEPS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
  end

  assign cos_out = neg_r ? -x_r : x_r;
  assign sin_out = neg_r ? -y_r : y_r;
  assign done    = done_r;

endmodule
